// ===== src/ebpc_pkg.sv =====
// Shared types, constants and the descriptor name table for the EDID patch/check block.
`timescale 1ns / 1ps
package ebpc_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned MFG_W    = 15;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DOFF_W   = 5;

	localparam logic [POS_W-1:0] DESC_START = 7'h36;
	localparam logic [POS_W-1:0] EXT_POS    = 7'h7e;
	localparam logic [POS_W-1:0] SUM_POS    = 7'h7f;
	localparam logic [POS_W-1:0] MFG_HI_POS = 7'd8;
	localparam logic [POS_W-1:0] MFG_LO_POS = 7'd9;
	localparam logic [POS_W-1:0] WEEK_POS   = 7'd16;
	localparam logic [POS_W-1:0] YEAR_POS   = 7'd17;
	localparam logic [POS_W-1:0] INDEF_POS  = 7'd20;
	localparam logic [DOFF_W-1:0] DESC_LAST_OFF = 5'd17;
	localparam logic [BYTE_W-1:0] NAME_TAG  = 8'hfc;
	localparam logic [BYTE_W-1:0] HDR_FILL  = 8'hff;

	// Register reset values
	localparam logic [MFG_W-1:0]  MFG_RST   = 15'd20757;
	localparam logic [BYTE_W-1:0] WEEK_RST  = 8'd50;
	localparam logic [BYTE_W-1:0] YEAR_RST  = 8'd25;
	localparam logic [BYTE_W-1:0] INDEF_RST = 8'h80;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MFG   = 2'd0,
		REG_WEEK  = 2'd1,
		REG_YEAR  = 2'd2,
		REG_INDEF = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [MFG_W-1:0]  mfg;
		logic [BYTE_W-1:0] week;
		logic [BYTE_W-1:0] year;
		logic [BYTE_W-1:0] indef;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] patched_byte;
		logic [POS_W-1:0]  byte_position;
		logic              block_end;
		logic              input_valid;
	} res_t;

	// Monitor-name text, indexed by descriptor offset 5..17
	function automatic logic [BYTE_W-1:0] name_byte(input logic [DOFF_W-1:0] off);
		logic [BYTE_W-1:0] b;
		case (off)
			5'd5:    b = 8'h44;
			5'd6:    b = 8'h61;
			5'd7:    b = 8'h6e;
			5'd8:    b = 8'h6d;
			5'd9:    b = 8'h61;
			5'd10:   b = 8'h6b;
			5'd11:   b = 8'h75;
			5'd12:   b = 8'h20;
			5'd13:   b = 8'h39;
			5'd14:   b = 8'h0a;
			default: b = 8'h20;
		endcase
		return b;
	endfunction

endpackage

// ===== src/ebpc_if.sv =====
// Valid/ready stream interfaces for raw and patched EDID bytes.
`timescale 1ns / 1ps
interface ebpc_in_if;
	logic                       valid;
	logic                       ready;
	logic [ebpc_pkg::BYTE_W-1:0] edid_byte;

	modport source (output valid, output edid_byte, input ready);
	modport sink   (input valid, input edid_byte, output ready);
endinterface

interface ebpc_out_if;
	logic                       valid;
	logic                       ready;
	logic [ebpc_pkg::BYTE_W-1:0] patched_byte;
	logic [ebpc_pkg::POS_W-1:0]  byte_position;
	logic                       block_end;
	logic                       input_valid;

	modport source (output valid, output patched_byte, output byte_position,
		output block_end, output input_valid, input ready);
	modport sink   (input valid, input patched_byte, input byte_position,
		input block_end, input input_valid, output ready);
endinterface

// ===== src/ebpc_patch.sv =====
// Per-block state and the byte patch / check logic, one byte per step.
`timescale 1ns / 1ps
module ebpc_patch (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [ebpc_pkg::BYTE_W-1:0] edid_byte,
	input  ebpc_pkg::cfg_t              cfg,
	output ebpc_pkg::res_t              res
);
	import ebpc_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [DOFF_W-1:0] doff_q;
	logic [BYTE_W-1:0] in_sum_q;
	logic [BYTE_W-1:0] out_sum_q;
	logic              hdr_good_q;
	logic              dzero_q;
	logic              name_on_q;

	logic              last;
	logic              in_desc;
	logic              hdr_ok;
	logic [BYTE_W-1:0] in_sum_nxt;
	logic [BYTE_W-1:0] o;
	logic              dzero_nxt;
	logic              name_on_nxt;

	assign last       = (pos_q == SUM_POS);
	assign in_desc    = (pos_q >= DESC_START) && (pos_q < EXT_POS);
	assign in_sum_nxt = in_sum_q + edid_byte;

	// header bytes: 00 FF FF FF FF FF FF 00
	always_comb begin
		hdr_ok = 1'b1;
		if (pos_q == 7'd0 || pos_q == 7'd7)
			hdr_ok = (edid_byte == '0);
		else if (pos_q < 7'd7)
			hdr_ok = (edid_byte == HDR_FILL);
	end

	// descriptor tag tracking and byte patching
	always_comb begin
		o           = edid_byte;
		dzero_nxt   = dzero_q;
		name_on_nxt = name_on_q;
		if (in_desc) begin
			case (doff_q)
				5'd0: begin
					dzero_nxt   = (edid_byte == '0);
					name_on_nxt = 1'b0;
				end
				5'd1, 5'd2: dzero_nxt = dzero_q && (edid_byte == '0);
				5'd3:       dzero_nxt = dzero_q && (edid_byte == NAME_TAG);
				5'd4:       name_on_nxt = dzero_q && (edid_byte == '0);
				default: begin
					if (name_on_q)
						o = name_byte(doff_q);
				end
			endcase
		end
		if (pos_q == MFG_HI_POS)
			o = {1'b0, cfg.mfg[MFG_W-1:BYTE_W]};
		else if (pos_q == MFG_LO_POS)
			o = cfg.mfg[BYTE_W-1:0];
		else if (pos_q == WEEK_POS)
			o = cfg.week;
		else if (pos_q == YEAR_POS)
			o = cfg.year;
		else if (pos_q == INDEF_POS)
			o = cfg.indef;
		else if (pos_q == EXT_POS)
			o = '0;
		if (last)
			o = BYTE_W'(0) - out_sum_q;
	end

	assign res.patched_byte  = o;
	assign res.byte_position = pos_q;
	assign res.block_end     = last;
	assign res.input_valid   = last && hdr_good_q && (in_sum_nxt == '0);

	// state update per byte; everything restarts after the checksum byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			doff_q     <= '0;
			in_sum_q   <= '0;
			out_sum_q  <= '0;
			hdr_good_q <= 1'b1;
			dzero_q    <= 1'b0;
			name_on_q  <= 1'b0;
		end else if (step) begin
			if (last) begin
				pos_q      <= '0;
				doff_q     <= '0;
				in_sum_q   <= '0;
				out_sum_q  <= '0;
				hdr_good_q <= 1'b1;
				dzero_q    <= 1'b0;
				name_on_q  <= 1'b0;
			end else begin
				pos_q      <= pos_q + 1'b1;
				doff_q     <= (in_desc && doff_q != DESC_LAST_OFF) ? doff_q + 1'b1 : '0;
				in_sum_q   <= in_sum_nxt;
				out_sum_q  <= out_sum_q + o;
				hdr_good_q <= hdr_good_q && hdr_ok;
				dzero_q    <= dzero_nxt;
				name_on_q  <= name_on_nxt;
			end
		end
	end

endmodule

// ===== src/edid_block_patch_and_check_top.sv =====
// Top level: config registers, input stage, patch unit and result register.
//
//  channel   dir  handshake    payload
//  byte_in   in   valid/ready  edid_byte[7:0]
//  byte_out  out  valid/ready  patched_byte[7:0], byte_position[6:0], block_end, input_valid
//  cfg       in   cfg_we       cfg_index[1:0], cfg_data[14:0]
//
// One byte per cycle sustained while byte_out is ready; an accepted byte
// passes through the input register, then the result register. The patch unit
// updates its block state only when a byte moves into the result register, so
// a stall on byte_out holds both stages and backs up byte_in. Reset clears
// the position counter, sums and flags and loads the register defaults.
`timescale 1ns / 1ps
module edid_block_patch_and_check_top (
	input  logic                           clk,
	input  logic                           arst_n,
	ebpc_in_if.sink                        byte_in,
	ebpc_out_if.source                     byte_out,
	input  logic                           cfg_we,
	input  logic [ebpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ebpc_pkg::MFG_W-1:0]     cfg_data
);
	import ebpc_pkg::*;

	cfg_t              cfg_q;
	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              vld_s2;
	res_t              res_s2;
	res_t              res;
	logic              adv_s2;
	logic              adv_s1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mfg   <= MFG_RST;
			cfg_q.week  <= WEEK_RST;
			cfg_q.year  <= YEAR_RST;
			cfg_q.indef <= INDEF_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MFG:   cfg_q.mfg   <= cfg_data;
				REG_WEEK:  cfg_q.week  <= cfg_data[BYTE_W-1:0];
				REG_YEAR:  cfg_q.year  <= cfg_data[BYTE_W-1:0];
				REG_INDEF: cfg_q.indef <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	assign adv_s2        = vld_s1 && (!vld_s2 || byte_out.ready);
	assign adv_s1        = byte_in.valid && byte_in.ready;
	assign byte_in.ready = !vld_s1 || adv_s2;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (byte_in.ready)
			vld_s1 <= byte_in.valid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			byte_s1 <= byte_in.edid_byte;
	end

	ebpc_patch u_patch (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s2),
		.edid_byte (byte_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (!vld_s2 || byte_out.ready)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2)
			res_s2 <= res;
	end

	assign byte_out.valid         = vld_s2;
	assign byte_out.patched_byte  = res_s2.patched_byte;
	assign byte_out.byte_position = res_s2.byte_position;
	assign byte_out.block_end     = res_s2.block_end;
	assign byte_out.input_valid   = res_s2.input_valid;

endmodule

// ===== bench/edid_patch_checker.sv =====
// Watches the EDID byte streams, predicts each patched byte and compares it.
`timescale 1ns / 1ps
module edid_patch_checker
	import ebpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	ebpc_in_if                   byte_in,
	ebpc_out_if                  byte_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	// Shadow copies of the config registers
	logic [MFG_W-1:0]  mfg_code = MFG_RST;
	logic [BYTE_W-1:0] week     = WEEK_RST;
	logic [BYTE_W-1:0] year     = YEAR_RST;
	logic [BYTE_W-1:0] indef    = INDEF_RST;

	// Block tracking state
	logic [POS_W-1:0]  pos_cnt   = '0;
	logic [BYTE_W-1:0] in_sum    = '0;
	logic [BYTE_W-1:0] out_sum   = '0;
	logic              hdr_ok    = 1'b1;
	logic              desc_zero = 1'b0;
	logic              name_on   = 1'b0;

	logic [BYTE_W-1:0] monitor_name [0:12];
	res_t              expected_bytes [$];
	int                err_cnt = 0;
	int                queued  = 0;

	assign mismatches  = err_cnt;
	assign outstanding = queued;

	initial monitor_name = '{8'h44, 8'h61, 8'h6e, 8'h6d, 8'h61, 8'h6b, 8'h75,
		8'h20, 8'h39, 8'h0a, 8'h20, 8'h20, 8'h20};

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic void start_block();
		pos_cnt   = '0;
		in_sum    = '0;
		out_sum   = '0;
		hdr_ok    = 1'b1;
		desc_zero = 1'b0;
		name_on   = 1'b0;
	endfunction

	// Patch one raw byte and advance the block state
	function automatic res_t patch_next_byte(input logic [BYTE_W-1:0] b);
		res_t              r;
		logic [BYTE_W-1:0] o;
		logic [DOFF_W-1:0] off;
		logic              last;
		o    = b;
		last = (pos_cnt == SUM_POS);

		// fixed header: 00 ff ff ff ff ff ff 00
		if (pos_cnt == 0 || pos_cnt == 7) begin
			if (b != 8'h00) hdr_ok = 1'b0;
		end else if (pos_cnt < 7) begin
			if (b != HDR_FILL) hdr_ok = 1'b0;
		end
		in_sum = in_sum + b;

		// monitor-name descriptor detection, on raw bytes only
		if (pos_cnt >= DESC_START && pos_cnt < EXT_POS) begin
			off = DOFF_W'((pos_cnt - DESC_START) % 18);
			case (off)
				5'd0: begin
					desc_zero = (b == 8'h00);
					name_on   = 1'b0;
				end
				5'd1, 5'd2: desc_zero = desc_zero && (b == 8'h00);
				5'd3:       desc_zero = desc_zero && (b == NAME_TAG);
				5'd4:       name_on   = desc_zero && (b == 8'h00);
				default: begin
					if (name_on) o = monitor_name[4'(off - 5'd5)];
				end
			endcase
		end

		case (pos_cnt)
			MFG_HI_POS: o = {1'b0, mfg_code[14:8]};
			MFG_LO_POS: o = mfg_code[7:0];
			WEEK_POS:   o = week;
			YEAR_POS:   o = year;
			INDEF_POS:  o = indef;
			EXT_POS:    o = 8'h00;
			default: ;
		endcase

		r.byte_position = pos_cnt;
		r.block_end     = last;
		r.input_valid   = 1'b0;
		if (last) begin
			o = -out_sum;
			r.input_valid = hdr_ok && (in_sum == 8'h00);
			start_block();
		end else begin
			out_sum = out_sum + o;
			pos_cnt = pos_cnt + 1'b1;
		end
		r.patched_byte = o;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			mfg_code = MFG_RST;
			week     = WEEK_RST;
			year     = YEAR_RST;
			indef    = INDEF_RST;
			start_block();
			expected_bytes.delete();
			queued = 0;
		end else begin
			// register writes are to happen only while the block is idle; the block itself does not enforce this
			if (cfg_we) begin
				case (cfg_index)
					REG_MFG:   mfg_code = cfg_data;
					REG_WEEK:  week     = cfg_data[7:0];
					REG_YEAR:  year     = cfg_data[7:0];
					REG_INDEF: indef    = cfg_data[7:0];
					default: ;
				endcase
			end

			// compare an outgoing beat with the oldest prediction
			if (byte_out.valid && byte_out.ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("beat at position %0d with nothing expected",
						byte_out.byte_position));
				end else begin
					want = expected_bytes.pop_front();
					if (byte_out.patched_byte !== want.patched_byte)
						report_mismatch($sformatf("pos %0d: patched_byte %h, expected %h",
							want.byte_position, byte_out.patched_byte, want.patched_byte));
					if (byte_out.byte_position !== want.byte_position)
						report_mismatch($sformatf("byte_position %0d, expected %0d",
							byte_out.byte_position, want.byte_position));
					if (byte_out.block_end !== want.block_end)
						report_mismatch($sformatf("pos %0d: block_end %b, expected %b",
							want.byte_position, byte_out.block_end, want.block_end));
					if (byte_out.input_valid !== want.input_valid)
						report_mismatch($sformatf("pos %0d: input_valid %b, expected %b",
							want.byte_position, byte_out.input_valid, want.input_valid));
				end
			end

			if (byte_in.valid && byte_in.ready)
				expected_bytes.push_back(patch_next_byte(byte_in.edid_byte));
			queued = expected_bytes.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Stimulus and verdict for the EDID patch/check block: crafted and random blocks.
`timescale 1ns / 1ps
module testbench;
	import ebpc_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MFG_W-1:0]     cfg_data;
	int                   err_cnt;
	int                   pend_cnt;
	bit                   quiet = 1'b0;

	// current 128-byte block being streamed
	logic [BYTE_W-1:0] blk [0:127];
	int                blk_idx = 128;

	ebpc_in_if  byte_in ();
	ebpc_out_if byte_out ();

	edid_block_patch_and_check_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.byte_out  (byte_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	edid_patch_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_in),
		.byte_out    (byte_out),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (err_cnt),
		.outstanding (pend_cnt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output back-pressure
	always @(posedge clk) begin
		byte_out.ready <= quiet || ($urandom_range(0, 99) >= 27);
	end

	// 18-byte descriptor head: 00 00 00 tag b4
	function automatic void set_desc(input int base, input logic [7:0] tag,
		input logic [7:0] b4);
		blk[base]     = 8'h00;
		blk[base + 1] = 8'h00;
		blk[base + 2] = 8'h00;
		blk[base + 3] = tag;
		blk[base + 4] = b4;
	endfunction

	function automatic void fix_checksum();
		logic [7:0] s;
		s = 8'h00;
		for (int i = 0; i < 127; i++) s = s + blk[i];
		blk[127] = -s;
	endfunction

	function automatic void set_header();
		for (int i = 0; i < 8; i++) blk[i] = (i == 0 || i == 7) ? 8'h00 : HDR_FILL;
	endfunction

	// Mostly well-formed blocks with random content, some broken, some noise
	function automatic void fill_block();
		int kind;
		int base;
		int k;
		logic [7:0] v;
		kind = $urandom_range(0, 99);
		for (int i = 0; i < 128; i++) blk[i] = 8'($urandom_range(0, 255));
		if (kind < 88) begin
			set_header();
			for (int d = 0; d < 4; d++) begin
				base = DESC_START + 18 * d;
				case ($urandom_range(0, 3))
					0: set_desc(base, NAME_TAG, 8'h00);
					1: begin
						// name descriptor with one head byte off
						set_desc(base, NAME_TAG, 8'h00);
						k = $urandom_range(0, 4);
						v = 8'($urandom_range(1, 255));
						if (k == 3 && v == NAME_TAG) v = 8'hfd;
						blk[base + k] = (k == 3) ? v - 8'h01 + (v == 8'h01 ? 8'h00 : 8'h01) : v;
					end
					2: set_desc(base, 8'($urandom_range(0, 255)), 8'h00);
					default: ;
				endcase
			end
			if (kind >= 70 && kind < 80) begin
				k = $urandom_range(0, 7);
				blk[k] = blk[k] ^ 8'($urandom_range(1, 255));
			end
			fix_checksum();
			if (kind >= 80) blk[127] = blk[127] + 8'($urandom_range(1, 255));
		end
		blk_idx = 0;
	endfunction

	function automatic logic [MFG_W-1:0] pick_reg_value(input int unsigned top);
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return MFG_W'(top);
			2:       return MFG_W'($urandom_range(0, 32767));
			default: return MFG_W'($urandom_range(0, top));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(0, 99) < 27) begin
			byte_in.valid <= 1'b0;
			@(posedge clk);
		end
		byte_in.valid     <= 1'b1;
		byte_in.edid_byte <= b;
		do @(posedge clk); while (!byte_in.ready);
	endtask

	task automatic stream_bytes(input int n);
		for (int i = 0; i < n; i++) begin
			if (blk_idx >= 128) fill_block();
			send_byte(blk[blk_idx]);
			blk_idx++;
		end
	endtask

	// Let every predicted beat come out, then cover the pipeline latency
	task automatic drain();
		byte_in.valid <= 1'b0;
		@(posedge clk);
		while (pend_cnt != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [MFG_W-1:0] mfg, input logic [MFG_W-1:0] wk,
		input logic [MFG_W-1:0] yr, input logic [MFG_W-1:0] idf);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MFG;
		cfg_data  <= mfg;
		@(posedge clk);
		cfg_index <= REG_WEEK;
		cfg_data  <= wk;
		@(posedge clk);
		cfg_index <= REG_YEAR;
		cfg_data  <= yr;
		@(posedge clk);
		cfg_index <= REG_INDEF;
		cfg_data  <= idf;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Run limit
	initial begin
		#2000000;
		$display("timeout with %0d results still due", pend_cnt);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int sent;
		int ph;
		int n;
		arst_n            = 1'b0;
		byte_in.valid     = 1'b0;
		byte_in.edid_byte = '0;
		cfg_we            = 1'b0;
		cfg_index         = REG_MFG;
		cfg_data          = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Crafted block at reset defaults: good header and sum, patched
		// fields raw 0xff, name descriptors first and last, near misses between
		for (int i = 8; i < 126; i++) blk[i] = (i % 2) ? 8'hff : 8'h00;
		set_header();
		blk[8]  = 8'hff;
		blk[16] = 8'hff;
		blk[20] = 8'hff;
		set_desc(54, NAME_TAG, 8'h00);
		set_desc(72, NAME_TAG, 8'h01);
		set_desc(90, 8'hfd, 8'h00);
		set_desc(108, NAME_TAG, 8'h00);
		blk[126] = 8'hff;
		fix_checksum();
		blk_idx = 0;
		stream_bytes(128);
		drain();

		// All registers zero, all-ones block: bad header, wrong sum
		program_regs('0, '0, '0, '0);
		for (int i = 0; i < 128; i++) blk[i] = 8'hff;
		blk_idx = 0;
		stream_bytes(128);
		drain();

		// All-ones data; byte registers keep only their low 8 bits
		program_regs('1, '1, '1, '1);
		blk_idx = 128;

		// Random phases; register changes often land mid-block
		// (the two crafted blocks count toward the total)
		sent = 256;
		ph   = 0;
		while (sent < 1450) begin
			n     = $urandom_range(60, 260);
			if (n > 1450 - sent) n = 1450 - sent;
			quiet = (ph == 2);
			stream_bytes(n);
			sent += n;
			drain();
			quiet = 1'b0;
			program_regs(pick_reg_value(32767), pick_reg_value(255),
				pick_reg_value(255), pick_reg_value(255));
			ph++;
		end
		drain();

		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ebpc_pkg.sv
src/ebpc_if.sv
src/ebpc_patch.sv
src/edid_block_patch_and_check_top.sv
bench/edid_patch_checker.sv
bench/testbench.sv
